// File: rtl/rsi_pkg.sv
// Package for the ray-sphere intersection unit: shared constants, register indexes
// and the width helpers that follow from the coordinate width.
// No dependencies.
package rsi_pkg;

    localparam int COORD_WIDTH_DEFAULT = 32;
    localparam int DIR_WIDTH           = 18;
    localparam int DIST_WIDTH          = 31;
    localparam int FRAC_BITS           = 16;
    localparam int QUEUE_DEPTH         = 8;
    localparam int CFG_INDEX_WIDTH     = 3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX       = {DIST_WIDTH{1'b1}};
    // 0.01 in Q16.16
    localparam logic [DIST_WIDTH-1:0] MIN_DIST_RESET = DIST_WIDTH'(655);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Z     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIUS       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DISTANCE = 3'd4;

    // Width of v = e.d after the drop to Q16.16.
    function automatic int v_width(input int coord_w);
        return coord_w + DIR_WIDTH + 3 - FRAC_BITS;
    endfunction

    // Width of the square root result; the discriminant fits in twice this.
    function automatic int sqrt_width(input int coord_w);
        return (v_width(coord_w) > 32) ? v_width(coord_w) : 32;
    endfunction

endpackage

// File: rtl/ray_sphere_intersection_unit.sv
// Top level of the ray-sphere intersection unit (geometric form, Q16.16).
// Depends on rsi_pkg, rsi_front, rsi_queue and rsi_back.
//
// Usage:
//   Rays enter on the s_t* stream, one beat per ray; every ray yields exactly one
//   result beat on the m_t* stream: m_tuser is the hit flag, m_tdata the distance.
//   The sphere is set through the cfg_* write channel (index 0..2 centre x/y/z,
//   3 radius, 4 minimum distance); unknown indexes are ignored. cfg_ready is
//   always high. Write the registers only while no ray is in flight.
//   Throughput is one ray per cycle while s_tready is high and the back part runs;
//   the square root, 37 bits wide at the default coordinate width, resolves one root
//   bit per stage.
//   The front part (difference, dot products, discriminant, five stages) never
//   stalls; a credit count keeps it from overrunning the eight-entry queue that
//   feeds the back part, and s_tready drops when all credits are taken.
//   The back part (square-root pipeline and output register) halts as a whole when
//   m_tvalid is high and m_tready low; the result then holds on m_t* unchanged.
//   Reset clears all valid bits, the queue and the credit count, and loads the
//   registers with centre 0, radius 0 and minimum distance 655 (about 0.01).
module ray_sphere_intersection_unit #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = rsi_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((3*COORD_WIDTH+3*rsi_pkg::DIR_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // distance, zero fill
    output logic [((rsi_pkg::DIST_WIDTH+7)/8)*8-1:0] m_tdata,
    // hit
    output logic m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [rsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((COORD_WIDTH > rsi_pkg::DIST_WIDTH) ? COORD_WIDTH
                   : rsi_pkg::DIST_WIDTH)-1:0] cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int DRW  = rsi_pkg::DIR_WIDTH;
    localparam int DSTW = rsi_pkg::DIST_WIDTH;
    localparam int VW   = rsi_pkg::v_width(COORD_WIDTH);
    localparam int SW   = rsi_pkg::sqrt_width(COORD_WIDTH);
    localparam int QW   = 1 + VW + 2 * SW;
    localparam int KW   = $clog2(QUEUE_DEPTH + 1);
    localparam int OW   = ((DSTW + 7) / 8) * 8;

    logic signed [CW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [DSTW-1:0]      radius_reg, min_distance_reg;
    logic [KW-1:0]        credit_reg;

    logic                 s_accept;
    logic                 f_valid, f_pos;
    logic signed [VW-1:0] f_v;
    logic [2*SW-1:0]      f_disc;
    logic [QW-1:0]        q_head;
    logic                 q_empty, q_pop;
    logic                 b_hit;
    logic [DSTW-1:0]      b_distance;

    assign cfg_ready = 1'b1;
    assign s_tready  = (credit_reg < KW'(QUEUE_DEPTH));
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            radius_reg       <= '0;
            min_distance_reg <= rsi_pkg::MIN_DIST_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rsi_pkg::CFG_CENTER_X:     center_x_reg     <= $signed(cfg_data[CW-1:0]);
                rsi_pkg::CFG_CENTER_Y:     center_y_reg     <= $signed(cfg_data[CW-1:0]);
                rsi_pkg::CFG_CENTER_Z:     center_z_reg     <= $signed(cfg_data[CW-1:0]);
                rsi_pkg::CFG_RADIUS:       radius_reg       <= cfg_data[DSTW-1:0];
                rsi_pkg::CFG_MIN_DISTANCE: min_distance_reg <= cfg_data[DSTW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // One credit per ray between acceptance and its departure from the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + KW'(s_accept) - KW'(q_pop);
        end
    end

    rsi_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_accept),
        .origin_x  ($signed(s_tdata[CW-1:0])),
        .origin_y  ($signed(s_tdata[2*CW-1:CW])),
        .origin_z  ($signed(s_tdata[3*CW-1:2*CW])),
        .dir_x     ($signed(s_tdata[3*CW+DRW-1:3*CW])),
        .dir_y     ($signed(s_tdata[3*CW+2*DRW-1:3*CW+DRW])),
        .dir_z     ($signed(s_tdata[3*CW+3*DRW-1:3*CW+2*DRW])),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius    (radius_reg),
        .out_valid (f_valid),
        .out_pos   (f_pos),
        .out_v     (f_v),
        .out_disc  (f_disc)
    );

    rsi_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data ({f_pos, f_v, f_disc}),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    rsi_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pos        (q_head[QW-1]),
        .q_v          ($signed(q_head[QW-2:2*SW])),
        .q_disc       (q_head[2*SW-1:0]),
        .q_pop        (q_pop),
        .min_distance (min_distance_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_hit      (b_hit),
        .out_distance (b_distance)
    );

    assign m_tuser = b_hit;
    assign m_tdata = OW'(b_distance);

endmodule

// File: rtl/rsi_front.sv
// Front part of the ray-sphere intersection unit: e = centre - origin, v = e.d,
// disc = r*r - e.e + v*v and the positive-discriminant flag. Uses rsi_pkg.
module rsi_front #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]                     origin_x,
    input  logic signed [COORD_WIDTH-1:0]                     origin_y,
    input  logic signed [COORD_WIDTH-1:0]                     origin_z,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]              dir_x,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]              dir_y,
    input  logic signed [rsi_pkg::DIR_WIDTH-1:0]              dir_z,
    input  logic signed [COORD_WIDTH-1:0]                     center_x,
    input  logic signed [COORD_WIDTH-1:0]                     center_y,
    input  logic signed [COORD_WIDTH-1:0]                     center_z,
    input  logic [rsi_pkg::DIST_WIDTH-1:0]                    radius,
    output logic                                              out_valid,
    output logic                                              out_pos,
    output logic signed [rsi_pkg::v_width(COORD_WIDTH)-1:0]   out_v,
    output logic [2*rsi_pkg::sqrt_width(COORD_WIDTH)-1:0]     out_disc
);

    localparam int DW_  = rsi_pkg::DIR_WIDTH;
    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = EW + DW_;
    localparam int VFW  = PW + 2;
    localparam int VW   = rsi_pkg::v_width(COORD_WIDTH);
    localparam int SW   = rsi_pkg::sqrt_width(COORD_WIDTH);
    localparam int EK   = (EW + 1) / 2;
    localparam int EHW  = EW - EK;
    localparam int EEW  = 2 * EW + 2;
    localparam int VK   = (VW + 1) / 2;
    localparam int VHW  = VW - VK;
    localparam int RRW  = 2 * rsi_pkg::DIST_WIDTH;
    localparam int DSW  = 2 * SW + 2;
    localparam int FB   = rsi_pkg::FRAC_BITS;

    logic [4:0] valid_reg;

    // stage 1
    logic signed [EW-1:0]  ex_reg, ey_reg, ez_reg;
    logic signed [DW_-1:0] dx_reg, dy_reg, dz_reg;
    // stage 2
    logic signed [PW-1:0]  pdx_reg, pdy_reg, pdz_reg;
    logic [2*EHW-1:0]      hh_reg [3];
    logic [EHW+EK-1:0]     hl_reg [3];
    logic [2*EK-1:0]       ll_reg [3];
    logic [RRW-1:0]        rr2_reg;
    // stage 3
    logic signed [VW-1:0]  v3_reg;
    logic [EEW-1:0]        ee3_reg;
    logic [RRW-1:0]        rr3_reg;
    // stage 4
    logic signed [VW-1:0]  v4_reg;
    logic [EEW-1:0]        ee4_reg;
    logic [RRW-1:0]        rr4_reg;
    logic [2*VHW-1:0]      vhh_reg;
    logic [VHW+VK-1:0]     vhl_reg;
    logic [2*VK-1:0]       vll_reg;
    // stage 5
    logic signed [VW-1:0]  v5_reg;
    logic [DSW-1:0]        disc_reg;

    logic [EW-1:0]         emag [3];
    logic signed [EW-1:0]  evec [3];
    logic [VFW-1:0]        vf_sum;
    logic [EEW-1:0]        ee_sum;
    logic [VW-1:0]         vmag;
    logic [2*VW-1:0]       vv_sum;

    assign evec[0] = ex_reg;
    assign evec[1] = ey_reg;
    assign evec[2] = ez_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            emag[i] = evec[i][EW-1] ? (~evec[i] + EW'(1)) : evec[i];
        end
        vf_sum = {{2{pdx_reg[PW-1]}}, pdx_reg} + {{2{pdy_reg[PW-1]}}, pdy_reg}
               + {{2{pdz_reg[PW-1]}}, pdz_reg};
        ee_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            ee_sum = ee_sum + (EEW'(hh_reg[i]) << (2 * EK))
                   + (EEW'(hl_reg[i]) << (EK + 1)) + EEW'(ll_reg[i]);
        end
        vmag   = v3_reg[VW-1] ? (~v3_reg + VW'(1)) : v3_reg;
        vv_sum = ((2*VW)'(vhh_reg) << (2 * VK)) + ((2*VW)'(vhl_reg) << (VK + 1))
               + (2*VW)'(vll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ex_reg <= $signed({center_x[COORD_WIDTH-1], center_x})
                - $signed({origin_x[COORD_WIDTH-1], origin_x});
        ey_reg <= $signed({center_y[COORD_WIDTH-1], center_y})
                - $signed({origin_y[COORD_WIDTH-1], origin_y});
        ez_reg <= $signed({center_z[COORD_WIDTH-1], center_z})
                - $signed({origin_z[COORD_WIDTH-1], origin_z});
        dx_reg <= dir_x;
        dy_reg <= dir_y;
        dz_reg <= dir_z;

        pdx_reg <= ex_reg * dx_reg;
        pdy_reg <= ey_reg * dy_reg;
        pdz_reg <= ez_reg * dz_reg;
        for (int i = 0; i < 3; i++)
        begin
            hh_reg[i] <= emag[i][EW-1:EK] * emag[i][EW-1:EK];
            hl_reg[i] <= emag[i][EW-1:EK] * emag[i][EK-1:0];
            ll_reg[i] <= emag[i][EK-1:0] * emag[i][EK-1:0];
        end
        rr2_reg <= radius * radius;

        v3_reg  <= $signed(vf_sum[VFW-1:FB]);
        ee3_reg <= ee_sum;
        rr3_reg <= rr2_reg;

        v4_reg  <= v3_reg;
        ee4_reg <= ee3_reg;
        rr4_reg <= rr3_reg;
        vhh_reg <= vmag[VW-1:VK] * vmag[VW-1:VK];
        vhl_reg <= vmag[VW-1:VK] * vmag[VK-1:0];
        vll_reg <= vmag[VK-1:0] * vmag[VK-1:0];

        v5_reg   <= v4_reg;
        disc_reg <= DSW'(rr4_reg) - DSW'(ee4_reg) + DSW'(vv_sum);
    end

    assign out_valid = valid_reg[4];
    assign out_v     = v5_reg;
    assign out_pos   = !disc_reg[DSW-1] && (disc_reg != '0);
    assign out_disc  = disc_reg[2*SW-1:0];

endmodule

// File: rtl/rsi_queue.sv
// Short register queue between the front and back parts of the ray-sphere unit.
// No dependencies.
module rsi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= bump(wr_reg);
            end
            if (pop)
            begin
                rd_reg <= bump(rd_reg);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_reg];
    assign empty = (count_reg == '0);

endmodule

// File: rtl/rsi_back.sv
// Back part of the ray-sphere unit: pipelined square root one bit per stage,
// root selection against the minimum distance and the output register. Uses rsi_pkg.
module rsi_back #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             q_empty,
    input  logic                                             q_pos,
    input  logic signed [rsi_pkg::v_width(COORD_WIDTH)-1:0]  q_v,
    input  logic [2*rsi_pkg::sqrt_width(COORD_WIDTH)-1:0]    q_disc,
    output logic                                             q_pop,
    input  logic [rsi_pkg::DIST_WIDTH-1:0]                   min_distance,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic                                             out_hit,
    output logic [rsi_pkg::DIST_WIDTH-1:0]                   out_distance
);

    localparam int VW = rsi_pkg::v_width(COORD_WIDTH);
    localparam int SW = rsi_pkg::sqrt_width(COORD_WIDTH);
    localparam int TW = 2 * SW;
    localparam int RW = SW + 2;

    logic                 adv;
    logic [SW:0]          valid_reg;
    logic [TW-1:0]        rem_reg  [SW+1];
    logic [SW-1:0]        root_reg [SW+1];
    logic signed [VW-1:0] v_reg    [SW+1];
    logic [SW:0]          pos_reg;
    logic [TW-1:0]        rem_next  [SW];
    logic [SW-1:0]        root_next [SW];
    logic [TW-1:0]        trial;

    logic signed [RW-1:0] t1, t2, tsel;
    logic                 t1_ok, t2_ok, hit_next;
    logic [rsi_pkg::DIST_WIDTH-1:0] dist_next;

    // The whole back part moves whenever the output register is free or being taken.
    assign adv   = !out_valid || out_ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        trial = '0;
        for (int k = 0; k < SW; k++)
        begin
            trial = (TW'(root_reg[k]) << (SW - k)) | (TW'(1) << (2 * (SW - 1 - k)));
            if (rem_reg[k] >= trial)
            begin
                rem_next[k]  = rem_reg[k] - trial;
                root_next[k] = root_reg[k] | (SW'(1) << (SW - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_reg[k];
                root_next[k] = root_reg[k];
            end
        end
    end

    always_comb
    begin
        t1    = RW'(v_reg[SW]) - $signed({2'b00, root_reg[SW]});
        t2    = RW'(v_reg[SW]) + $signed({2'b00, root_reg[SW]});
        t1_ok = !t1[RW-1] && (t1[RW-2:0] > (RW-1)'(min_distance));
        t2_ok = !t2[RW-1] && (t2[RW-2:0] > (RW-1)'(min_distance));
        tsel  = t1_ok ? t1 : t2;
        hit_next = pos_reg[SW] && (t1_ok || t2_ok);
        if (!hit_next)
        begin
            dist_next = '0;
        end
        else if (tsel[RW-2:0] > (RW-1)'(rsi_pkg::DIST_MAX))
        begin
            dist_next = rsi_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = tsel[rsi_pkg::DIST_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[SW-1:0], !q_empty};
            out_valid <= valid_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= q_disc;
            root_reg[0] <= '0;
            v_reg[0]    <= q_v;
            pos_reg[0]  <= q_pos;
            for (int k = 0; k < SW; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                v_reg[k+1]    <= v_reg[k];
                pos_reg[k+1]  <= pos_reg[k];
            end
            out_hit      <= hit_next;
            out_distance <= dist_next;
        end
    end

endmodule

// File: test/ray_sphere_intersection_unit_test.sv
// Self-checking testbench for ray_sphere_intersection_unit: streams rays, predicts
// each hit flag and distance, and checks every result beat in order.
// Depends on rsi_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module ray_sphere_intersection_unit_test;
    import rsi_pkg::*;

    localparam int CW      = 32;
    localparam int S_BITS  = ((3*CW + 3*DIR_WIDTH + 7)/8)*8;
    localparam int M_BITS  = ((DIST_WIDTH + 7)/8)*8;
    localparam int STALL_LIMIT = 4000;  // cycles without any beat while work is pending
    localparam int DRAIN_CYCLES = 60;   // wait at the end before the final check

    typedef struct packed {
        logic signed [DIR_WIDTH-1:0] dz;
        logic signed [DIR_WIDTH-1:0] dy;
        logic signed [DIR_WIDTH-1:0] dx;
        logic signed [CW-1:0]        oz;
        logic signed [CW-1:0]        oy;
        logic signed [CW-1:0]        ox;
    } ray_t;

    typedef struct packed {
        logic                  hit;
        logic [DIST_WIDTH-1:0] distance;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    // Shadow copy of the sphere registers, loaded with the reset values.
    logic signed [CW-1:0]  sph_cx = '0, sph_cy = '0, sph_cz = '0;
    logic [DIST_WIDTH-1:0] sph_radius = '0;
    logic [DIST_WIDTH-1:0] sph_min = MIN_DIST_RESET;

    ray_t rays_pending[$];
    hit_t hits_expected[$];
    bit   calm = 1'b0;      // when set, neither side idles or stalls
    bit   failed = 1'b0;
    int   quiet_cycles = 0;

    always #5 clk = ~clk;

    ray_sphere_intersection_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Geometric ray-sphere test in fixed point. The dot product is floored to Q16.16,
    // the discriminant is kept exact at 128 bits and its floor square root is Q16.16.
    function automatic hit_t sphere_hit(ray_t r);
        longint ex, ey, ez, dx, dy, dz, vf, v, s, t;
        logic signed [127:0] disc;
        logic [127:0] root_sq;
        hit_t res;
        ex = longint'(sph_cx) - longint'(r.ox);
        ey = longint'(sph_cy) - longint'(r.oy);
        ez = longint'(sph_cz) - longint'(r.oz);
        dx = longint'(r.dx);
        dy = longint'(r.dy);
        dz = longint'(r.dz);
        vf = ex*dx + ey*dy + ez*dz;
        v = vf >>> 16;
        disc = longint'(sph_radius) * longint'(sph_radius) - (ex*ex + ey*ey + ez*ez) + v*v;
        res = '0;
        // A tangent ray (disc of zero) counts as a miss.
        if (disc <= 0)
            return res;
        s = 0;
        for (int b = 56; b >= 0; b--)
        begin
            root_sq = 128'(s | (64'sd1 <<< b));
            if (root_sq * root_sq <= 128'(disc))
                s = s | (64'sd1 <<< b);
        end
        // Nearest root beyond the minimum distance; roots behind the origin never count.
        if (v - s > 0 && v - s > longint'(sph_min))
            t = v - s;
        else if (v + s > 0 && v + s > longint'(sph_min))
            t = v + s;
        else
            return res;
        res.hit = 1'b1;
        res.distance = (t > longint'(DIST_MAX)) ? DIST_MAX : t[DIST_WIDTH-1:0];
        return res;
    endfunction

    // Driver: records the prediction for every accepted beat and offers the next ray.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                hits_expected.push_back(sphere_hit(ray_t'(s_tdata[$bits(ray_t)-1:0])));
            if (!s_tvalid || s_tready)
            begin
                if (rays_pending.size() > 0 && (calm || $urandom_range(99) >= 7))
                begin
                    s_tdata <= S_BITS'(rays_pending.pop_front());
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction, stalls at
    // random, and keeps a watchdog on progress.
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n)
        begin
            m_tready <= calm || $urandom_range(99) >= 7;
            if (m_tvalid && m_tready)
            begin
                if (hits_expected.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: hit %0b distance %h",
                             $time, m_tuser, m_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    want = hits_expected.pop_front();
                    if (m_tuser !== want.hit)
                    begin
                        $display("%0t: hit flag expected %0b actual %0b", $time, want.hit,
                                 m_tuser);
                        failed = 1'b1;
                    end
                    if (m_tdata !== M_BITS'(want.distance))
                    begin
                        $display("%0t: distance expected %h actual %h", $time,
                                 M_BITS'(want.distance), m_tdata);
                        failed = 1'b1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || (rays_pending.size() == 0 && hits_expected.size() == 0 && !s_tvalid))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("ray_sphere_intersection_unit_test failed");
                $finish;
            end
        end
    end

    // Writes one register and mirrors it into the shadow copy once the beat is taken.
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_X:     sph_cx = value;
            CFG_CENTER_Y:     sph_cy = value;
            CFG_CENTER_Z:     sph_cz = value;
            CFG_RADIUS:       sph_radius = value[DIST_WIDTH-1:0];
            CFG_MIN_DISTANCE: sph_min = value[DIST_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                              logic [CW-1:0] radius, logic [CW-1:0] min_dist);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_MIN_DISTANCE, min_dist);
    endtask

    // Waits until every ray has gone in and every result has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (rays_pending.size() > 0 || s_tvalid || hits_expected.size() > 0);
    endtask

    function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                      int dx, int dy, int dz);
        ray_t r;
        r.ox = CW'(ox); r.oy = CW'(oy); r.oz = CW'(oz);
        r.dx = DIR_WIDTH'(dx); r.dy = DIR_WIDTH'(dy); r.dz = DIR_WIDTH'(dz);
        return r;
    endfunction

    function automatic longint to_fix(real x);
        if (x > 32767.99) x = 32767.99;
        if (x < -32768.0) x = -32768.0;
        return $rtoi(x * 65536.0);
    endfunction

    function automatic real jitter();
        return $urandom_range(2000) / 1000.0 - 1.0;
    endfunction

    // A ray from somewhere around the sphere aimed near its centre, unit length.
    function automatic ray_t aimed_ray();
        real c[3], o[3], d[3], rad, len;
        ray_t r;
        c[0] = $itor(sph_cx) / 65536.0;
        c[1] = $itor(sph_cy) / 65536.0;
        c[2] = $itor(sph_cz) / 65536.0;
        rad = $itor(sph_radius) / 65536.0 + 0.001;
        len = 0.0;
        for (int k = 0; k < 3; k++)
        begin
            o[k] = c[k] + 4.0 * rad * jitter();
            d[k] = c[k] + 1.2 * rad * jitter() - o[k];
            len += d[k] * d[k];
        end
        len = $sqrt(len);
        if (len < 1.0e-9)
        begin
            d[0] = 1.0; d[1] = 0.0; d[2] = 0.0; len = 1.0;
        end
        r = make_ray(to_fix(o[0]), to_fix(o[1]), to_fix(o[2]),
                     $rtoi(d[0] / len * 65535.0), $rtoi(d[1] / len * 65535.0),
                     $rtoi(d[2] / len * 65535.0));
        return r;
    endfunction

    // Any ray at all: full-range origin, direction components from -65536 to 65536.
    function automatic ray_t noise_ray();
        return make_ray(longint'(signed'($urandom)), longint'(signed'($urandom)),
                        longint'(signed'($urandom)), int'($urandom_range(131072)) - 65536,
                        int'($urandom_range(131072)) - 65536,
                        int'($urandom_range(131072)) - 65536);
    endfunction

    task automatic random_rays(int count, int aimed_pct);
        for (int k = 0; k < count; k++)
            rays_pending.push_back(($urandom_range(99) < aimed_pct) ? aimed_ray() : noise_ray());
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: radius 0, so nearly every ray misses.
        random_rays(60, 50);

        // Directed rays against a unit sphere at the origin.
        set_sphere(0, 0, 0, 32'h0001_0000, 32'd655);
        write_reg(CFG_INDEX_WIDTH'(5), 32'hFFFF_FFFF);          // unknown index, ignored
        write_reg(CFG_INDEX_WIDTH'(7), 32'h1234_5678);
        rays_pending.push_back(make_ray(-32'sh50000, 0, 0, 65536, 0, 0));   // straight hit
        rays_pending.push_back(make_ray(-32'sh50000, 32'sh10000, 0, 65536, 0, 0)); // tangent
        rays_pending.push_back(make_ray(32'sh50000, 0, 0, 65536, 0, 0));    // sphere behind
        rays_pending.push_back(make_ray(0, 0, 0, 0, 0, 65536));             // from inside
        rays_pending.push_back(make_ray(0, 0, 0, 0, 0, 0));                 // zero direction
        rays_pending.push_back(make_ray(32'sh8000, 0, 0, 0, 0, 0));
        rays_pending.push_back(make_ray(0, -32'sh50000, 0, 0, 65536, 0));
        rays_pending.push_back(make_ray(0, 0, 32'sh50000, 0, 0, -65536));
        rays_pending.push_back(make_ray(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                                        65536, 65536, 65536));
        rays_pending.push_back(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                        -65536, -65536, -65536));
        rays_pending.push_back(make_ray(32'sh7FFF_FFFF, -32'sh8000_0000, 0,
                                        -65536, 65536, 0));
        rays_pending.push_back(make_ray(-32'sh30000, 32'shFFFF, 0, 65535, -1, 1));
        drain();
        // Stray high bit on the radius is dropped; largest radius saturates distances.
        set_sphere(0, 0, 0, 32'hFFFF_FFFF, 32'd0);
        rays_pending.push_back(make_ray(-32'sh8000_0000, 0, 0, 65536, 0, 0));
        rays_pending.push_back(make_ray(0, 0, 0, -65536, 0, 0));
        rays_pending.push_back(make_ray(32'sh7FFF_FFFF, 0, 0, -65536, 0, 0));
        rays_pending.push_back(make_ray(0, 0, 0, 0, 0, 0));
        drain();
        // Largest minimum distance: nothing can count as a hit.
        set_sphere(0, 0, 0, 32'h0010_0000, 32'h7FFF_FFFF);
        rays_pending.push_back(make_ray(-32'sh50000, 0, 0, 65536, 0, 0));
        rays_pending.push_back(make_ray(0, 0, 0, 0, 65536, 0));
        drain();

        // Random phases over a range of spheres.
        set_sphere(32'h000A_0000, 32'hFFFC_8000, 32'h0007_4000, 32'h0002_0000, 32'd655);
        random_rays(300, 85);
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0064_0000, 32'd0);
        random_rays(250, 85);
        set_sphere(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'd0);
        random_rays(200, 85);
        set_sphere($urandom, $urandom, $urandom, 32'h0005_0000, 32'h7FFF_FFFF);
        random_rays(150, 85);
        calm = 1'b1;
        set_sphere(32'h0001_8000, 32'h0002_8000, 32'hFFFD_0000, 32'h0000_8000, 32'h0003_0000);
        random_rays(300, 85);
        calm = 1'b0;
        set_sphere($urandom, $urandom, $urandom, $urandom, $urandom_range(32'h0004_0000));
        random_rays(300, 85);
        set_sphere(32'h0, 32'h0, 32'h0, 32'h0032_0000, 32'd655);
        random_rays(250, 85);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && hits_expected.size() == 0)
            $display("ray_sphere_intersection_unit_test passed");
        else
            $display("ray_sphere_intersection_unit_test failed");
        $finish;
    end

endmodule
